FILE: design/nrn_pkg.sv
// ----------------------------------------------------------------------------
// nrn_pkg: shared types and constants of the n-th root unit
// Fixed-point widths, saturation limits, sequencer states and result status
// codes used by the root sequencer and its arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package nrn_pkg;

  // Defaults of the top-level parameters.
  localparam int MAX_DEGREE_DEF     = 32;
  localparam int FRAC_BITS_DEF      = 16;
  localparam int MAX_ITERATIONS_DEF = 64;

  // Port widths.
  localparam int RAD_W  = 32;
  localparam int DEG_W  = 6;
  localparam int TOL_W  = 16;
  localparam int ROOT_W = 48;
  localparam int STS_W  = 2;

  // Internal widths: estimate, power and quotient.
  localparam int X_W = 57;
  localparam int P_W = 63;
  localparam int Q_W = 61;

  // Shared multiplier operand and product widths.
  localparam int MUL_W  = 64;
  localparam int PROD_W = 2 * MUL_W;

  // Default dividend width of the shared divider.
  localparam int DVD_W_DEF = 64;

  localparam logic [X_W-1:0]    EST_CAP      = X_W'(1) << 56;
  localparam logic [P_W-1:0]    POW_CAP      = P_W'(1) << 62;
  localparam logic [Q_W-1:0]    QUO_CAP      = Q_W'(1) << 60;
  localparam logic [ROOT_W-1:0] OUT_MAX      = {1'b0, {(ROOT_W-1){1'b1}}};
  localparam logic [ROOT_W-1:0] OUT_MIN_MAG  = {1'b1, {(ROOT_W-1){1'b0}}};
  localparam logic [TOL_W-1:0]  TOL_RESET    = TOL_W'(66);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_POW_ISSUE,
    S_POW_MUL,
    S_QDIV,
    S_NX_MUL,
    S_VDIV,
    S_TOL_MUL,
    S_CHECK
  } state_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK       = 2'd0,
    STS_DEG_ZERO = 2'd1,
    STS_NEG_EVEN = 2'd2,
    STS_NO_CONV  = 2'd3
  } status_t;

endpackage

`default_nettype wire

FILE: design/nrn_mul.sv
// ----------------------------------------------------------------------------
// nrn_mul: shared multi-cycle multiplier
// Forms a full 64 by 64 product from four registered 32 by 32 partial
// products, accumulated one per cycle; done pulses when the product is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module nrn_mul
  import nrn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [MUL_W-1:0]  a,
  input  wire logic [MUL_W-1:0]  b,
  output logic                   done,
  output logic [PROD_W-1:0]      prod
);

  localparam int HALF = MUL_W / 2;
  localparam logic [2:0] PH_LAST = 3'd4;

  logic              active_r;
  logic [2:0]        ph_r;
  logic              pv_r;
  logic              done_r;
  logic [1:0]        ps_r;
  logic [MUL_W-1:0]  a_r;
  logic [MUL_W-1:0]  b_r;
  logic [MUL_W-1:0]  pp_r;
  logic [PROD_W-1:0] acc_r;
  logic [HALF-1:0]   a_sel;
  logic [HALF-1:0]   b_sel;
  logic [PROD_W-1:0] pp_shift;

  always_comb begin
    a_sel = ph_r[0] ? a_r[MUL_W-1:HALF] : a_r[HALF-1:0];
    b_sel = ph_r[1] ? b_r[MUL_W-1:HALF] : b_r[HALF-1:0];
    case (ps_r)
      2'd0:    pp_shift = PROD_W'(pp_r);
      2'd1:    pp_shift = PROD_W'(pp_r) << HALF;
      default: pp_shift = PROD_W'(pp_r) << MUL_W;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ph_r     <= '0;
      pv_r     <= 1'b0;
      done_r   <= 1'b0;
    end else if (start) begin
      active_r <= 1'b1;
      ph_r     <= '0;
      pv_r     <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= active_r && (ph_r == PH_LAST);
      if (active_r) begin
        ph_r     <= ph_r + 3'd1;
        pv_r     <= !ph_r[2];
        active_r <= (ph_r != PH_LAST);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (active_r) begin
      if (!ph_r[2]) begin
        pp_r <= MUL_W'(a_sel) * MUL_W'(b_sel);
        ps_r <= {1'b0, ph_r[0]} + {1'b0, ph_r[1]};
      end
      if (pv_r) begin
        acc_r <= acc_r + pp_shift;
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

FILE: design/nrn_div.sv
// ----------------------------------------------------------------------------
// nrn_div: shared restoring divider
// Unsigned division producing one quotient bit a cycle; done pulses when the
// quotient is ready. The divisor must be non-zero.
// ----------------------------------------------------------------------------
`default_nettype none

module nrn_div
  import nrn_pkg::*;
#(
  parameter int DVD_W = DVD_W_DEF,
  parameter int DVS_W = P_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             active_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             qbit;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    qbit  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else if (start) begin
      active_r <= 1'b1;
      done_r   <= 1'b0;
      cnt_r    <= CNT_W'(DVD_W);
    end else begin
      done_r <= active_r && (cnt_r == CNT_W'(1));
      if (active_r) begin
        cnt_r    <= cnt_r - CNT_W'(1);
        active_r <= (cnt_r != CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (active_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      rem_r <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule

`default_nettype wire

FILE: design/nth_root_newton.sv
// ----------------------------------------------------------------------------
// nth_root_newton: n-th root of a signed integer by Newton iteration
// Sequencer around a shared multiplier and a shared bit-serial divider.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low, and its result appears
// on out_root and out_status for exactly one cycle with out_valid high; the
// receiver cannot hold it off. Degree zero, a zero radicand and an even root
// of a negative number give their result in the cycle after acceptance and
// leave the block ready. Any other item runs Newton steps until the estimate
// settles or the step limit is reached. With n the clamped degree and D the
// divider width (64 with sixteen fraction bits), each step runs the n - 1
// power multiplies on the shared multiplier, a D-bit division on the divider,
// which yields one quotient bit a cycle, the multiply of the estimate by
// n - 1 and a second D-bit division. Each step after the first also has a
// tolerance multiply and a check; busy stays high until the last step ends,
// and the result is registered from that step.
// Tolerance is written through the cfg beat channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module nth_root_newton
  import nrn_pkg::*;
#(
  parameter int MAX_DEGREE     = MAX_DEGREE_DEF,
  parameter int FRAC_BITS      = FRAC_BITS_DEF,
  parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic signed [RAD_W-1:0]  in_radicand,
  input  wire logic [DEG_W-1:0]         in_degree,
  output logic                          out_valid,
  output logic signed [ROOT_W-1:0]      out_root,
  output logic [STS_W-1:0]              out_status,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [TOL_W-1:0]         cfg_tolerance
);

  localparam int NUM_W = RAD_W + 2 * FRAC_BITS;
  localparam int DVD_W = (NUM_W > MUL_W) ? NUM_W : MUL_W;
  localparam int IT_W  = $clog2(MAX_ITERATIONS + 1);

  state_t state_r;
  state_t state_nxt;

  logic [TOL_W-1:0]  tol_r;
  logic              neg_r;
  logic [RAD_W-1:0]  mag_r;
  logic [DEG_W-1:0]  n_r;
  logic [DEG_W-1:0]  e_r;
  logic [X_W-1:0]    x_r;
  logic [X_W-1:0]    nx_r;
  logic [P_W-1:0]    p_r;
  logic [Q_W-1:0]    q_r;
  logic [X_W-1:0]    lim_r;
  logic [IT_W-1:0]   it_r;
  logic              out_valid_r;
  logic [ROOT_W-1:0] out_root_r;
  status_t           out_status_r;

  logic              accept;
  logic [RAD_W-1:0]  rad_u;
  logic              in_neg;
  logic [RAD_W-1:0]  in_mag;
  logic [DEG_W-1:0]  in_n;
  logic              early;
  status_t           early_sts;

  logic              mul_go;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic              div_go;
  logic [DVD_W-1:0]  div_a;
  logic [P_W-1:0]    div_b;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;

  logic [P_W-1:0]    p_new;
  logic [P_W-1:0]    den;
  logic [Q_W-1:0]    qv;
  logic [X_W-1:0]    nxv;
  logic [MUL_W-1:0]  vsum;
  logic [X_W-1:0]    lim;
  logic              first_step;
  logic [IT_W-1:0]   it_inc;
  logic              last;
  logic              first_last;
  logic              close;

  logic              fin;
  logic [X_W-1:0]    fin_res;
  logic              fin_neg;
  status_t           fin_sts;
  logic              fin_sat;
  logic [ROOT_W-1:0] fin_mag;
  logic [ROOT_W-1:0] fin_root;

  nrn_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  nrn_div #(
    .DVD_W (DVD_W),
    .DVS_W (P_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_comb begin
    rad_u  = in_radicand;
    in_neg = rad_u[RAD_W-1];
    in_mag = in_neg ? (~rad_u + RAD_W'(1)) : rad_u;
    in_n   = (in_degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : in_degree;
    early     = 1'b1;
    early_sts = STS_OK;
    if (in_degree == '0) begin
      early_sts = STS_DEG_ZERO;
    end else if (in_mag == '0) begin
      early_sts = STS_OK;
    end else if (in_neg && !in_n[0]) begin
      early_sts = STS_NEG_EVEN;
    end else begin
      early = 1'b0;
    end
  end

  always_comb begin
    p_new = (mul_prod > PROD_W'(POW_CAP)) ? POW_CAP
                                          : mul_prod[P_W+FRAC_BITS-1:FRAC_BITS];
    den   = (p_r == '0) ? P_W'(1) : p_r;
    qv    = (div_quo >= DVD_W'(QUO_CAP)) ? QUO_CAP : div_quo[Q_W-1:0];
    nxv   = (div_quo > DVD_W'(EST_CAP)) ? EST_CAP : div_quo[X_W-1:0];
    vsum  = mul_prod[MUL_W-1:0] + MUL_W'(q_r);
    lim   = mul_prod[X_W+TOL_W-1:TOL_W];
    first_step = (it_r == '0);
    it_inc     = it_r + IT_W'(1);
    last       = (it_inc == IT_W'(MAX_ITERATIONS));
    first_last = (IT_W'(1) == IT_W'(MAX_ITERATIONS));
    close      = (x_r <= nx_r) || ((x_r - nx_r) <= lim_r);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && !early) state_nxt = S_STEP;
      end
      S_STEP: begin
        state_nxt = S_POW_ISSUE;
      end
      S_POW_ISSUE: begin
        state_nxt = (e_r == '0) ? S_QDIV : S_POW_MUL;
      end
      S_POW_MUL: begin
        if (mul_done) state_nxt = S_POW_ISSUE;
      end
      S_QDIV: begin
        if (div_done) state_nxt = S_NX_MUL;
      end
      S_NX_MUL: begin
        if (mul_done) state_nxt = S_VDIV;
      end
      S_VDIV: begin
        if (div_done) begin
          if (!first_step) state_nxt = S_TOL_MUL;
          else if (first_last) state_nxt = S_IDLE;
          else state_nxt = S_STEP;
        end
      end
      S_TOL_MUL: begin
        if (mul_done) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = (close || last) ? S_IDLE : S_STEP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    mul_go  = 1'b0;
    mul_a   = MUL_W'(p_r);
    mul_b   = MUL_W'(x_r);
    div_go  = 1'b0;
    div_a   = DVD_W'(mag_r) << (2 * FRAC_BITS);
    div_b   = den;
    fin     = 1'b0;
    fin_res = nx_r;
    fin_neg = neg_r;
    fin_sts = STS_OK;
    unique case (state_r)
      S_IDLE: begin
        fin     = accept && early;
        fin_res = '0;
        fin_neg = 1'b0;
        fin_sts = early_sts;
      end
      S_POW_ISSUE: begin
        mul_go = (e_r != '0);
        div_go = (e_r == '0);
      end
      S_QDIV: begin
        mul_go = div_done;
        mul_a  = MUL_W'(n_r - DEG_W'(1));
        mul_b  = MUL_W'(x_r);
      end
      S_NX_MUL: begin
        div_go = mul_done;
        div_a  = DVD_W'(vsum);
        div_b  = P_W'(n_r);
      end
      S_VDIV: begin
        mul_go  = div_done && !first_step;
        mul_a   = MUL_W'(nxv);
        mul_b   = MUL_W'(tol_r);
        fin     = div_done && first_step && first_last;
        fin_res = nxv;
        fin_sts = STS_NO_CONV;
      end
      S_CHECK: begin
        fin     = close || last;
        fin_sts = close ? STS_OK : STS_NO_CONV;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fin_sat  = (fin_res > X_W'(OUT_MAX));
    fin_mag  = fin_sat ? (fin_neg ? OUT_MIN_MAG : OUT_MAX) : fin_res[ROOT_W-1:0];
    fin_root = fin_neg ? (~fin_mag + ROOT_W'(1)) : fin_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tol_r       <= TOL_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_tolerance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_root_r   <= fin_root;
      out_status_r <= fin_sts;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          neg_r <= in_neg;
          mag_r <= in_mag;
          n_r   <= in_n;
          x_r   <= X_W'(1) << FRAC_BITS;
          it_r  <= '0;
        end
      end
      S_STEP: begin
        p_r <= P_W'(1) << FRAC_BITS;
        e_r <= n_r - DEG_W'(1);
      end
      S_POW_MUL: begin
        if (mul_done) begin
          p_r <= p_new;
          e_r <= e_r - DEG_W'(1);
        end
      end
      S_QDIV: begin
        if (div_done) q_r <= qv;
      end
      S_VDIV: begin
        if (div_done) begin
          if (first_step) begin
            x_r  <= nxv;
            it_r <= IT_W'(1);
          end else begin
            nx_r <= nxv;
          end
        end
      end
      S_TOL_MUL: begin
        if (mul_done) lim_r <= lim;
      end
      S_CHECK: begin
        if (!close) begin
          x_r  <= nx_r;
          it_r <= it_inc;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_root   = $signed(out_root_r);
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_degree == '0) |=>
      (out_valid && out_status == STS_DEG_ZERO && out_root == '0))
    else $error("degree zero did not give its result in the next cycle");

  a_neg_even_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_NEG_EVEN) |-> (out_root == '0))
    else $error("even root of a negative number gave a non-zero root");

  a_est_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (x_r <= EST_CAP))
    else $error("estimate exceeds its saturation limit");

  a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_POW_MUL || state_r == S_NX_MUL ||
                  state_r == S_TOL_MUL))
    else $error("multiplier finished outside a state that waits for it");
`endif

endmodule

`default_nettype wire
